// ===== rtl/ssf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_pkg: shared types and constants of the separation force block
// Fixed-point formats, datapath widths, register indexes and the queue entry.
// ----------------------------------------------------------------------------
package ssf_pkg;

    // Position fraction bits and gain fraction bits
    localparam int FRAC_BITS  = 8;
    localparam int GAIN_FRAC  = 8;

    localparam int POS_W      = 24;             // position field width
    localparam int DIFF_W     = POS_W + 1;      // dx, dy and their magnitudes
    localparam int RAD_W      = 20;             // radius width
    localparam int GAIN_W     = 16;             // gain width
    localparam int ID_W       = 16;             // agent id width
    localparam int FORCE_W    = 32;             // accumulator / result width
    localparam int CFG_IDX_W  = 8;              // config index width
    localparam int CFG_DATA_W = 20;             // config data width

    localparam int SQ_W       = 2 * DIFF_W;     // one squared axis
    localparam int SUM_W      = SQ_W + 1;       // squared distance
    localparam int RR_W       = 2 * RAD_W;      // radius squared
    localparam int PR_W       = GAIN_W + RAD_W; // gain * (radius - dist)
    localparam int PR_LO_W    = PR_W / 2;
    localparam int PR_HI_W    = PR_W - PR_LO_W;
    localparam int NUM_W      = DIFF_W + PR_W;  // numerator before scaling
    localparam int DIV_W      = NUM_W + FRAC_BITS;
    localparam int DEN_W      = RR_W;
    localparam int CNT_W      = $clog2(DIV_W);
    localparam int SQRT_STEPS = RAD_W;

    // Squared-distance threshold: floor(0.01 * 2^(2*FRAC_BITS))
    localparam logic [SUM_W-1:0] EPS_SQ = SUM_W'((64'd1 << (2 * FRAC_BITS)) / 100);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEP_RADIUS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_GAIN = CFG_IDX_W'(1);

    localparam logic [RAD_W-1:0]  SEP_RADIUS_RST = RAD_W'(5120);
    localparam logic [GAIN_W-1:0] FORCE_GAIN_RST = GAIN_W'(256);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Classified pair between front and back
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic                     skip;
        logic                     last;
    } ssf_item_t;

endpackage

// ===== rtl/ssf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_front: request intake and classification
// Forms dx, dy and the equal-id skip flag and pushes them to the queue.
// ----------------------------------------------------------------------------
module ssf_front import ssf_pkg::*; (
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [POS_W-1:0] s_self_x,
    input  logic signed [POS_W-1:0] s_self_y,
    input  logic [ID_W-1:0]         s_self_id,
    input  logic signed [POS_W-1:0] s_nbr_x,
    input  logic signed [POS_W-1:0] s_nbr_y,
    input  logic [ID_W-1:0]         s_nbr_id,
    input  logic                    s_last_pair,
    input  logic                    q_full,
    output logic                    q_push,
    output ssf_item_t               q_item
);

    // Accept whenever the queue has room
    assign s_ready = aresetn && !q_full;
    assign q_push  = s_valid && s_ready;

    // Classify the request
    always_comb begin
        q_item.dx   = DIFF_W'(s_self_x) - DIFF_W'(s_nbr_x);
        q_item.dy   = DIFF_W'(s_self_y) - DIFF_W'(s_nbr_y);
        q_item.skip = (s_self_id == s_nbr_id);
        q_item.last = s_last_pair;
    end

endmodule

// ===== rtl/ssf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_queue: short queue between front and back
// Register-based FIFO of classified requests; lets both sides stall on their own.
// ----------------------------------------------------------------------------
module ssf_queue import ssf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  ssf_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output ssf_item_t head_item
);

    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    ssf_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_QW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/ssf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_back: force engine
// Squares, range test, bit-pair square root, scaling multiplies, restoring
// divider per axis, saturating accumulate and the result register.
// ----------------------------------------------------------------------------
module ssf_back import ssf_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_empty,
    input  ssf_item_t                 q_item,
    output logic                      q_pop,
    input  logic [RAD_W-1:0]          sep_radius,
    input  logic [GAIN_W-1:0]         force_gain,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [FORCE_W-1:0] m_force_x,
    output logic signed [FORCE_W-1:0] m_force_y
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_SQ   = 10'b00_0000_0010,
        ST_CHK  = 10'b00_0000_0100,
        ST_SQRT = 10'b00_0000_1000,
        ST_MUL1 = 10'b00_0001_0000,
        ST_MUL2 = 10'b00_0010_0000,
        ST_MUL3 = 10'b00_0100_0000,
        ST_DIV  = 10'b00_1000_0000,
        ST_ACC  = 10'b01_0000_0000,
        ST_FIN  = 10'b10_0000_0000
    } state_t;

    state_t                    state_reg, state_next;
    ssf_item_t                 item_reg, item_next;
    logic [DIFF_W-1:0]         ax_reg, ax_next, ay_reg, ay_next;
    logic [SQ_W-1:0]           axx_reg, axx_next, ayy_reg, ayy_next;
    logic [RR_W-1:0]           rr_reg, rr_next;
    logic [RR_W-1:0]           sq_reg, sq_next;
    logic [RAD_W+2:0]          srem_reg, srem_next;
    logic [RAD_W-1:0]          root_reg, root_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [PR_W-1:0]           pr_reg, pr_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic [DIFF_W+PR_LO_W-1:0] plo_reg, plo_next;
    logic [DIV_W-1:0]          n_reg, n_next;
    logic [DIV_W-1:0]          q_reg, q_next;
    logic [DEN_W-1:0]          drem_reg, drem_next;
    logic                      axis_reg, axis_next;
    logic signed [FORCE_W-1:0] acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [FORCE_W-1:0] m_x_reg, m_x_next, m_y_reg, m_y_next;

    // Combinational helpers
    logic [SUM_W-1:0]             s_sum;
    logic [RAD_W+4:0]             srem_sh, strial;
    logic [DEN_W:0]               drem_sh, ddiff;
    logic [DIFF_W-1:0]            mag_cur;
    logic [DIFF_W+PR_HI_W-1:0]    phi;
    logic [NUM_W-1:0]             num;
    logic                         q_ovf;
    logic [FORCE_W:0]             part_mag;
    logic signed [FORCE_W+2:0]    part, acc_sum, acc_sat_in;
    logic signed [FORCE_W-1:0]    acc_cur, acc_new;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign m_valid   = m_valid_reg;
    assign m_force_x = m_x_reg;
    assign m_force_y = m_y_reg;

    // Shared arithmetic of the sequencer
    always_comb begin
        s_sum    = {1'b0, axx_reg} + {1'b0, ayy_reg};
        srem_sh  = {srem_reg, sq_reg[RR_W-1 -: 2]};
        strial   = {3'b000, root_reg, 2'b01};
        drem_sh  = {drem_reg, n_reg[DIV_W-1]};
        ddiff    = drem_sh - {1'b0, den_reg};
        mag_cur  = axis_reg ? ay_reg : ax_reg;
        phi      = mag_cur * pr_reg[PR_W-1:PR_LO_W];
        num      = {phi, {PR_LO_W{1'b0}}} + NUM_W'(plo_reg);
        q_ovf    = |q_reg[DIV_W-1:GAIN_FRAC+FORCE_W+1];
        part_mag = q_ovf ? '1 : q_reg[GAIN_FRAC+FORCE_W:GAIN_FRAC];
        part     = (axis_reg ? item_reg.dy[DIFF_W-1] : item_reg.dx[DIFF_W-1])
                   ? -$signed({2'b00, part_mag}) : $signed({2'b00, part_mag});
        acc_cur  = axis_reg ? acc_y_reg : acc_x_reg;
        acc_sat_in = (FORCE_W+3)'(acc_cur);
        acc_sum  = acc_sat_in + part;
        if (acc_sum > (FORCE_W+3)'(signed'({1'b0, {(FORCE_W-1){1'b1}}}))) begin
            acc_new = {1'b0, {(FORCE_W-1){1'b1}}};
        end else if (acc_sum < -(FORCE_W+3)'(signed'({2'b01, {(FORCE_W-1){1'b0}}}))) begin
            acc_new = {1'b1, {(FORCE_W-1){1'b0}}};
        end else begin
            acc_new = acc_sum[FORCE_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        axx_next     = axx_reg;
        ayy_next     = ayy_reg;
        rr_next      = rr_reg;
        sq_next      = sq_reg;
        srem_next    = srem_reg;
        root_next    = root_reg;
        cnt_next     = cnt_reg;
        pr_next      = pr_reg;
        den_next     = den_reg;
        plo_next     = plo_reg;
        n_next       = n_reg;
        q_next       = q_reg;
        drem_next    = drem_reg;
        axis_next    = axis_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    item_next  = q_item;
                    ax_next    = q_item.dx[DIFF_W-1] ? DIFF_W'(-q_item.dx) : q_item.dx;
                    ay_next    = q_item.dy[DIFF_W-1] ? DIFF_W'(-q_item.dy) : q_item.dy;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                axx_next   = ax_reg * ax_reg;
                ayy_next   = ay_reg * ay_reg;
                rr_next    = sep_radius * sep_radius;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                // Range test: not skipped, inside radius and beyond epsilon
                if (!item_reg.skip && (s_sum < SUM_W'(rr_reg)) && (s_sum > EPS_SQ)) begin
                    sq_next    = s_sum[RR_W-1:0];
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SQRT: begin
                // One result bit per step
                sq_next = {sq_reg[RR_W-3:0], 2'b00};
                if (srem_sh >= strial) begin
                    srem_next = (RAD_W+3)'(srem_sh - strial);
                    root_next = {root_reg[RAD_W-2:0], 1'b1};
                end else begin
                    srem_next = srem_sh[RAD_W+2:0];
                    root_next = {root_reg[RAD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if ((root_reg != '0) && (root_reg < sep_radius)) begin
                    pr_next    = force_gain * (sep_radius - root_reg);
                    den_next   = root_reg * sep_radius;
                    axis_next  = 1'b0;
                    state_next = ST_MUL2;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL2: begin
                plo_next   = mag_cur * pr_reg[PR_LO_W-1:0];
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                n_next     = {num, {FRAC_BITS{1'b0}}};
                q_next     = '0;
                drem_next  = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // Restoring divide, one quotient bit per step
                n_next = {n_reg[DIV_W-2:0], 1'b0};
                if (!ddiff[DEN_W]) begin
                    drem_next = ddiff[DEN_W-1:0];
                    q_next    = {q_reg[DIV_W-2:0], 1'b1};
                end else begin
                    drem_next = drem_sh[DEN_W-1:0];
                    q_next    = {q_reg[DIV_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (axis_reg) begin
                    acc_y_next = acc_new;
                    state_next = ST_FIN;
                end else begin
                    acc_x_next = acc_new;
                    axis_next  = 1'b1;
                    state_next = ST_MUL2;
                end
            end
            ST_FIN: begin
                // Last pair: hand the sums to the result register once it is free; other pairs return to idle
                if (!item_reg.last) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_x_next     = acc_x_reg;
                    m_y_next     = acc_y_reg;
                    acc_x_next   = '0;
                    acc_y_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            acc_x_reg   <= acc_x_next;
            acc_y_reg   <= acc_y_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        axx_reg  <= axx_next;
        ayy_reg  <= ayy_next;
        rr_reg   <= rr_next;
        sq_reg   <= sq_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        pr_reg   <= pr_next;
        den_reg  <= den_next;
        plo_reg  <= plo_next;
        n_reg    <= n_next;
        q_reg    <= q_next;
        drem_reg <= drem_next;
        axis_reg <= axis_next;
        m_x_reg  <= m_x_next;
        m_y_reg  <= m_y_next;
    end

`ifndef SYNTHESIS
    // Emitting a result clears both accumulators
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && item_reg.last && !m_valid_reg)
        |=> (acc_x_reg == '0 && acc_y_reg == '0))
        else $error("accumulators not cleared after emit");

    // A result appears only out of the finish step
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside finish step");

    // The divider is never entered with a zero denominator
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (den_reg != '0))
        else $error("divide by zero in force engine");
`endif

endmodule

// ===== rtl/swarm_separation_force.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarm_separation_force: boids separation force accumulator
// Throughput: one pair at a time, set by the 20-step square root and the bit-serial
//   divider run once per axis; a last pair waits while a result is unaccepted.
// Reset: synchronous, active low; clears accumulators, queue and result valid and
//   loads radius 5120 and gain 256.
// ----------------------------------------------------------------------------
module swarm_separation_force import ssf_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [POS_W-1:0]   s_self_x,
    input  logic signed [POS_W-1:0]   s_self_y,
    input  logic [ID_W-1:0]           s_self_id,
    input  logic signed [POS_W-1:0]   s_nbr_x,
    input  logic signed [POS_W-1:0]   s_nbr_y,
    input  logic [ID_W-1:0]           s_nbr_id,
    input  logic                      s_last_pair,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [FORCE_W-1:0] m_force_x,
    output logic signed [FORCE_W-1:0] m_force_y
);

    logic [RAD_W-1:0]  sep_radius_reg;
    logic [GAIN_W-1:0] force_gain_reg;
    logic              q_full, q_push, q_empty, q_pop;
    ssf_item_t         push_item, head_item;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_radius_reg <= SEP_RADIUS_RST;
            force_gain_reg <= FORCE_GAIN_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_SEP_RADIUS) begin
                sep_radius_reg <= cfg_data[RAD_W-1:0];
            end else if (cfg_index == REG_FORCE_GAIN) begin
                force_gain_reg <= cfg_data[GAIN_W-1:0];
            end
        end
    end

    ssf_front u_front (
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_self_x    (s_self_x),
        .s_self_y    (s_self_y),
        .s_self_id   (s_self_id),
        .s_nbr_x     (s_nbr_x),
        .s_nbr_y     (s_nbr_y),
        .s_nbr_id    (s_nbr_id),
        .s_last_pair (s_last_pair),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    ssf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    ssf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .sep_radius (sep_radius_reg),
        .force_gain (force_gain_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_force_x  (m_force_x),
        .m_force_y  (m_force_y)
    );

endmodule
